### rtl/core/suu_pkg.sv
package suu_pkg;

    // input word as it arrives on the item channel
    typedef struct packed {
        logic        operation;
        logic [7:0]  unit;
        logic [30:0] value;
        logic [4:0]  bit_count;
        logic        ack;
    } t_in_word;

    // result word, one per accepted input word
    typedef struct packed {
        logic [7:0] data_port;
        logic       data_line;
        logic       clock_line;
        logic       busy_res;
        logic       unit_done;
        logic       verify_error;
        logic [7:0] done_unit;
        logic       queued;
        logic       overflow;
    } t_out_word;

    // command kinds decided by the front
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_SKIP   = 2'd2;

    // classified command held in the queue
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  unit;
        logic [30:0] value;
        logic [4:0]  len;
        logic        ack;
    } t_cmd;

    // configuration write toward the back
    typedef struct packed {
        logic       valid;
        logic       index;
        logic [3:0] data;
    } t_cfg_wr;

    localparam int C_QUEUE_DEPTH = 4;

endpackage

### rtl/core/suu_front.sv
module suu_front
    import suu_pkg::*;
#(
    parameter int UNIT_COUNT = 256
) (
    input  logic     i_in_valid,
    input  t_in_word i_in_word,
    input  logic     i_q_full,
    output logic     o_in_stall,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam logic       OP_TICK     = 1'b0;
    localparam int         C_MAX_BITS  = 31;
    localparam logic [4:0] LP_MAX_BITS = 5'(C_MAX_BITS);
    localparam logic [8:0] LP_UNITS    = 9'(UNIT_COUNT);

    logic       in_range;
    logic [4:0] sat_len;

    // accept whenever the queue has room
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // bit count clamp and unit range check
    always_comb begin
        in_range = ({1'b0, i_in_word.unit} < LP_UNITS);
        if (i_in_word.bit_count == 5'd0) begin
            sat_len = 5'd1;
        end else if (i_in_word.bit_count > LP_MAX_BITS) begin
            sat_len = LP_MAX_BITS;
        end else begin
            sat_len = i_in_word.bit_count;
        end
    end

    // classify the word
    always_comb begin
        o_cmd.unit  = i_in_word.unit;
        o_cmd.value = i_in_word.value;
        o_cmd.len   = sat_len;
        o_cmd.ack   = i_in_word.ack;
        if (i_in_word.operation == OP_TICK) begin
            o_cmd.kind = CMD_TICK;
        end else if (in_range) begin
            o_cmd.kind = CMD_UPDATE;
        end else begin
            o_cmd.kind = CMD_SKIP;
        end
    end

endmodule

### rtl/core/suu_queue.sv
module suu_queue
    import suu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int AW = $clog2(C_QUEUE_DEPTH);
    localparam int CW = $clog2(C_QUEUE_DEPTH + 1);

    t_cmd          r_mem [C_QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(C_QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= AW'((int'(r_wr_ptr) + 1) % C_QUEUE_DEPTH);
            end
            if (i_pop) begin
                r_rd_ptr <= AW'((int'(r_rd_ptr) + 1) % C_QUEUE_DEPTH);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/suu_back.sv
module suu_back
    import suu_pkg::*;
#(
    parameter int UNIT_COUNT  = 256,
    parameter int STACK_DEPTH = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam int UAW = $clog2(UNIT_COUNT);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int FW  = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_CLOCK   = 3'd1;
    localparam logic [2:0] PH_VERIFY  = 3'd2;
    localparam logic [2:0] PH_LATCH   = 3'd3;
    localparam logic [2:0] PH_RELEASE = 3'd4;

    localparam logic [1:0] POP_NONE  = 2'd0;
    localparam logic [1:0] POP_STACK = 2'd1;
    localparam logic [1:0] POP_TABLE = 2'd2;

    localparam logic CFG_ACK_POLARITY = 1'b0;
    localparam logic CFG_MAX_READS    = 1'b1;

    localparam logic [3:0] C_READS_RESET = 4'd4;
    localparam logic [3:0] C_READS_SAT   = 4'd15;

    // unit table: value and length, valid bits in flops
    logic [35:0]           r_tab_mem [UNIT_COUNT];
    logic [UNIT_COUNT-1:0] r_tab_valid;
    logic [35:0]           r_rd_word;
    logic                  r_fwd_hit;
    logic [30:0]           r_fwd_val;

    // pending stack
    logic [UAW-1:0] r_stk_mem [STACK_DEPTH];
    logic [UAW-1:0] r_stk_rd;
    logic [FW-1:0]  r_fill;
    logic [FW-1:0]  n_fill;

    // execute slot
    logic       r_b_valid;
    t_cmd       r_b_cmd;
    logic [1:0] r_pop_step;
    logic [1:0] n_pop_step;

    // transfer engine
    logic [2:0]     r_phase;
    logic [2:0]     n_phase;
    logic [UAW-1:0] r_cur_unit;
    logic [UAW-1:0] n_cur_unit;
    logic [30:0]    r_shift;
    logic [30:0]    n_shift;
    logic [4:0]     r_bits;
    logic [4:0]     n_bits;
    logic [3:0]     r_reads;
    logic [3:0]     n_reads;
    logic           r_err;
    logic           n_err;
    logic           r_lv_data;
    logic           n_lv_data;
    logic           r_lv_clk;
    logic           n_lv_clk;

    // configuration
    logic       r_ack_pol;
    logic [3:0] r_max_reads;

    // output register
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out;

    logic           out_free;
    logic           b_done;
    logic           b_step;
    logic           st_en;
    logic           tab_we;
    logic           stk_we;
    logic           stk_re;
    logic           tab_re;
    logic [UAW-1:0] tab_raddr;
    logic [UAW-1:0] upd_unit;
    logic [UAW-1:0] pop_unit;
    logic [30:0]    cur_val;
    logic           sample;
    logic           mismatch;
    logic [3:0]     reads_inc;
    logic           q_pop;

    assign out_free = !r_out_valid || !i_out_stall;
    assign upd_unit = r_b_cmd.unit[UAW-1:0];
    assign pop_unit = ({1'b0, r_stk_rd} < (UAW + 1)'(UNIT_COUNT)) ? r_stk_rd : '0;
    assign cur_val  = r_fwd_hit ? r_fwd_val : r_rd_word[35:5];
    assign sample   = r_b_cmd.ack ^ r_ack_pol;
    assign mismatch = sample ^ r_lv_data;
    assign reads_inc = (r_reads < C_READS_SAT) ? (r_reads + 4'd1) : r_reads;

    // execute one command from the slot
    always_comb begin
        n_fill     = r_fill;
        n_pop_step = r_pop_step;
        n_phase    = r_phase;
        n_cur_unit = r_cur_unit;
        n_shift    = r_shift;
        n_bits     = r_bits;
        n_reads    = r_reads;
        n_err      = r_err;
        n_lv_data  = r_lv_data;
        n_lv_clk   = r_lv_clk;
        b_done     = 1'b0;
        b_step     = 1'b0;
        tab_we     = 1'b0;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        n_out      = '0;
        if (r_b_valid) begin
            case (r_b_cmd.kind)
                CMD_UPDATE: begin
                    b_done = out_free;
                    if (out_free && !(r_tab_valid[upd_unit] && cur_val == r_b_cmd.value)) begin
                        tab_we = 1'b1;
                        if (r_fill < FW'(STACK_DEPTH)) begin
                            stk_we       = 1'b1;
                            n_fill       = r_fill + FW'(1);
                            n_out.queued = 1'b1;
                        end else begin
                            n_out.overflow = 1'b1;
                        end
                    end
                end
                CMD_TICK: begin
                    if (r_pop_step == POP_STACK) begin
                        // stack entry arrives, fetch its table row
                        b_step     = 1'b1;
                        n_pop_step = POP_TABLE;
                    end else if (r_pop_step == POP_TABLE) begin
                        // table row arrives, select the unit
                        b_done = out_free;
                        if (out_free) begin
                            n_pop_step = POP_NONE;
                            n_cur_unit = pop_unit;
                            n_shift    = r_tab_valid[pop_unit] ? r_rd_word[35:5] : '1;
                            n_bits     = (r_rd_word[4:0] == 5'd0) ? 5'd1 : r_rd_word[4:0];
                            n_err      = 1'b0;
                            n_reads    = 4'd0;
                            n_lv_clk   = 1'b1;
                            n_lv_data  = ~n_shift[0];
                            n_phase    = PH_CLOCK;
                        end
                    end else begin
                        case (r_phase)
                            PH_CLOCK: begin
                                b_done   = out_free;
                                n_lv_clk = ~r_lv_clk;
                                n_reads  = 4'd0;
                                n_phase  = PH_VERIFY;
                            end
                            PH_VERIFY: begin
                                b_done  = out_free;
                                n_reads = reads_inc;
                                if (!(mismatch && reads_inc < r_max_reads)) begin
                                    if (mismatch) begin
                                        n_err = 1'b1;
                                    end
                                    n_bits = r_bits - 5'd1;
                                    if (n_bits == 5'd0) begin
                                        n_phase = PH_LATCH;
                                    end else begin
                                        n_shift   = {1'b0, r_shift[30:1]};
                                        n_lv_clk  = 1'b1;
                                        n_lv_data = ~n_shift[0];
                                        n_phase   = PH_CLOCK;
                                    end
                                end
                            end
                            PH_LATCH: begin
                                b_done  = out_free;
                                n_phase = PH_RELEASE;
                            end
                            PH_RELEASE: begin
                                b_done             = out_free;
                                n_lv_clk           = 1'b1;
                                n_lv_data          = 1'b0;
                                n_phase            = PH_IDLE;
                                n_out.unit_done    = 1'b1;
                                n_out.verify_error = r_err;
                                n_out.done_unit    = 8'(r_cur_unit);
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                if (r_fill == '0) begin
                                    b_done = out_free;
                                end else begin
                                    // start a pop: read the top of stack
                                    b_step     = 1'b1;
                                    stk_re     = 1'b1;
                                    n_fill     = r_fill - FW'(1);
                                    n_pop_step = POP_STACK;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    b_done = out_free;
                end
            endcase
        end
        // line and select state after the step
        if (n_phase == PH_CLOCK || n_phase == PH_VERIFY || n_phase == PH_RELEASE) begin
            n_out.data_port = 8'(n_cur_unit);
        end
        n_out.data_line  = n_lv_data;
        n_out.clock_line = n_lv_clk;
        n_out.busy_res   = (n_phase != PH_IDLE);
    end

    assign st_en   = b_done || b_step;
    assign q_pop   = i_q_valid && (!r_b_valid || b_done);
    assign o_q_pop = q_pop;

    // table read port: next command or the popped unit
    assign tab_re    = q_pop || (r_b_valid && r_pop_step == POP_STACK);
    assign tab_raddr = (r_pop_step == POP_STACK) ? pop_unit : i_q_cmd.unit[UAW-1:0];

    // unit table
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[upd_unit] <= {r_b_cmd.value, r_b_cmd.len};
        end
        if (tab_re) begin
            r_rd_word <= r_tab_mem[tab_raddr];
        end
    end

    // bypass for a read issued at the edge of a write to the same unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (q_pop) begin
            r_fwd_hit <= tab_we && (upd_unit == i_q_cmd.unit[UAW-1:0]);
        end else if (tab_re) begin
            r_fwd_hit <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_fwd_val <= r_b_cmd.value;
        end
    end

    // pending stack
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[r_fill[SAW-1:0]] <= upd_unit;
        end
        if (stk_re) begin
            r_stk_rd <= r_stk_mem[n_fill[SAW-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_valid <= '0;
            r_fill      <= '0;
            r_b_valid   <= 1'b0;
            r_pop_step  <= POP_NONE;
            r_phase     <= PH_IDLE;
            r_cur_unit  <= '0;
            r_shift     <= '0;
            r_bits      <= '0;
            r_reads     <= '0;
            r_err       <= 1'b0;
            r_lv_data   <= 1'b0;
            r_lv_clk    <= 1'b1;
            r_ack_pol   <= 1'b0;
            r_max_reads <= C_READS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (tab_we) begin
                r_tab_valid[upd_unit] <= 1'b1;
            end
            if (q_pop) begin
                r_b_valid <= 1'b1;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end
            if (st_en) begin
                r_fill     <= n_fill;
                r_pop_step <= n_pop_step;
                r_phase    <= n_phase;
                r_cur_unit <= n_cur_unit;
                r_shift    <= n_shift;
                r_bits     <= n_bits;
                r_reads    <= n_reads;
                r_err      <= n_err;
                r_lv_data  <= n_lv_data;
                r_lv_clk   <= n_lv_clk;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_ACK_POLARITY: r_ack_pol   <= i_cfg.data[0];
                    CFG_MAX_READS:    r_max_reads <= i_cfg.data;
                    default:          r_ack_pol   <= r_ack_pol;
                endcase
            end
            if (b_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // slot command and result payload
    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_b_cmd <= i_q_cmd;
        end
        if (b_done) begin
            r_out_word <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // a pop sequence only runs for a tick while the engine is idle
    a_pop_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pop_step != POP_NONE) |-> (r_b_valid && r_b_cmd.kind == CMD_TICK
                                      && r_phase == PH_IDLE))
        else $error("pop sequence outside an idle tick");

    // a queued word grows the stack by exactly one
    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_done && n_out.queued) |=> (r_fill == $past(r_fill) + FW'(1)))
        else $error("stack fill did not follow a push");

    // shifting phases always have bits left
    a_bits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CLOCK || r_phase == PH_VERIFY) |-> (r_bits != 5'd0))
        else $error("shift phase with no bits left");

    // a pop start leads to the stack read step
    a_pop_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stk_re) |=> (r_pop_step == POP_STACK))
        else $error("pop start did not advance");

endmodule

### rtl/core/serial_unit_update_shifter_unit.sv
// path: a word is accepted into a 4-entry queue, moves into the execute slot, and its
// result is then held in the output register when nothing stalls
// throughput: one word per cycle when neither the input nor the output stalls; a tick that
// selects a new unit holds the execute slot through stack read, then table read, then load
// reset: synchronous active low; clears queue, stack fill, engine, table valid bits
module serial_unit_update_shifter_unit
    import suu_pkg::*;
#(
    parameter int UNIT_COUNT  = 256,
    parameter int STACK_DEPTH = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    logic    q_full;
    logic    q_push;
    logic    q_valid;
    logic    q_pop;
    t_cmd    front_cmd;
    t_cmd    q_cmd;
    t_cfg_wr cfg_wr;

    // configuration writes are always taken
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    // front: accept and classify
    suu_front #(
        .UNIT_COUNT(UNIT_COUNT)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    // command queue between front and back
    suu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back: table, stack and transfer engine
    suu_back #(
        .UNIT_COUNT  (UNIT_COUNT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
